/* hdl/asl_pkg.sv */
// ----------------------------------------------------------------------------
// asl_pkg: shared types, constants and decode functions
// Token kinds, character codes, lexer modes and the result record used by
// the source lexer core, its output queue and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package asl_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int LINE_BITS   = 16;
  localparam int COL_BITS    = 16;
  localparam int LEN_BITS    = 12;
  localparam int KIND_BITS   = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

  typedef logic [KIND_BITS-1:0]   kind_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [LINE_BITS-1:0]   line_t;
  typedef logic [COL_BITS-1:0]    col_t;
  typedef logic [LEN_BITS-1:0]    len_t;

  localparam kind_t KIND_NONE        = 6'd0;
  localparam kind_t KIND_WORD        = 6'd1;
  localparam kind_t KIND_NUMBER      = 6'd2;
  localparam kind_t KIND_STRING_DB   = 6'd3;
  localparam kind_t KIND_STRING_SG   = 6'd4;
  localparam kind_t KIND_RBRAC_O     = 6'd5;
  localparam kind_t KIND_RBRAC_C     = 6'd6;
  localparam kind_t KIND_CBRAC_O     = 6'd7;
  localparam kind_t KIND_CBRAC_C     = 6'd8;
  localparam kind_t KIND_SBRAC_O     = 6'd9;
  localparam kind_t KIND_SBRAC_C     = 6'd10;
  localparam kind_t KIND_MACRO_O     = 6'd11;
  localparam kind_t KIND_MACRO_C     = 6'd12;
  localparam kind_t KIND_NEWLINE     = 6'd14;
  localparam kind_t KIND_HASH        = 6'd15;
  localparam kind_t KIND_COLON       = 6'd16;
  localparam kind_t KIND_PLUS        = 6'd17;
  localparam kind_t KIND_MINUS       = 6'd18;
  localparam kind_t KIND_SLASH       = 6'd19;
  localparam kind_t KIND_BITSHIFT_L  = 6'd20;
  localparam kind_t KIND_BITSHIFT_R  = 6'd21;
  localparam kind_t KIND_BITW_OR     = 6'd22;
  localparam kind_t KIND_BITW_AND    = 6'd23;
  localparam kind_t KIND_BITW_XOR    = 6'd24;
  localparam kind_t KIND_BSLASH      = 6'd25;
  localparam kind_t KIND_ASTERISK    = 6'd26;
  localparam kind_t KIND_QUEST       = 6'd27;
  localparam kind_t KIND_EXCLA       = 6'd28;
  localparam kind_t KIND_DOT         = 6'd29;
  localparam kind_t KIND_COMMA       = 6'd30;
  localparam kind_t KIND_RANGE       = 6'd31;
  localparam kind_t KIND_DOLLAR      = 6'd32;
  localparam kind_t KIND_SMALLER     = 6'd33;
  localparam kind_t KIND_GREATER     = 6'd34;
  localparam kind_t KIND_EQ_SMALLER  = 6'd35;
  localparam kind_t KIND_EQ_GREATER  = 6'd36;
  localparam kind_t KIND_EOT         = 6'd37;

  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_EXCLA    = 8'h21;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_AMP      = 8'h26;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_DIGIT_0  = 8'h30;
  localparam logic [7:0] CH_DIGIT_9  = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_LESS     = 8'h3C;
  localparam logic [7:0] CH_EQUAL    = 8'h3D;
  localparam logic [7:0] CH_GREATER  = 8'h3E;
  localparam logic [7:0] CH_QUEST    = 8'h3F;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CH_LBRACK   = 8'h5B;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_RBRACK   = 8'h5D;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_UNDER    = 8'h5F;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_B  = 8'h62;
  localparam logic [7:0] CH_LOWER_F  = 8'h66;
  localparam logic [7:0] CH_LOWER_X  = 8'h78;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_PIPE     = 8'h7C;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUMBER,
    MODE_STRING,
    MODE_HOLD,
    MODE_COMMENT
  } mode_t;

  typedef struct packed {
    kind_t   kind;
    offset_t start_offset;
    line_t   line_no;
    col_t    column;
    len_t    length;
    logic    error;
    logic    last;
  } result_t;

  typedef struct packed {
    logic    a_valid;
    result_t a;
    logic    b_valid;
    result_t b;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  endfunction

  function automatic logic is_num_tail(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) ||
           (c == CH_LOWER_X) || (c == CH_LOWER_B);
  endfunction

  function automatic logic is_hold_lead(input logic [7:0] c);
    return (c == CH_SLASH) || (c == CH_LESS) || (c == CH_GREATER) ||
           (c == CH_HASH) || (c == CH_COLON);
  endfunction

  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_LPAREN:  k = KIND_RBRAC_O;
      CH_RPAREN:  k = KIND_RBRAC_C;
      CH_LBRACE:  k = KIND_CBRAC_O;
      CH_RBRACE:  k = KIND_CBRAC_C;
      CH_LBRACK:  k = KIND_SBRAC_O;
      CH_RBRACK:  k = KIND_SBRAC_C;
      CH_HASH:    k = KIND_HASH;
      CH_COLON:   k = KIND_COLON;
      CH_PLUS:    k = KIND_PLUS;
      CH_MINUS:   k = KIND_MINUS;
      CH_SLASH:   k = KIND_SLASH;
      CH_PIPE:    k = KIND_BITW_OR;
      CH_AMP:     k = KIND_BITW_AND;
      CH_CARET:   k = KIND_BITW_XOR;
      CH_BSLASH:  k = KIND_BSLASH;
      CH_STAR:    k = KIND_ASTERISK;
      CH_QUEST:   k = KIND_QUEST;
      CH_EXCLA:   k = KIND_EXCLA;
      CH_DOT:     k = KIND_DOT;
      CH_COMMA:   k = KIND_COMMA;
      CH_DOLLAR:  k = KIND_DOLLAR;
      CH_LESS:    k = KIND_SMALLER;
      CH_GREATER: k = KIND_GREATER;
      default:    k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t pair_kind(input logic [7:0] h, input logic [7:0] c);
    kind_t k;
    k = KIND_NONE;
    if (h == CH_LESS && c == CH_LESS) k = KIND_BITSHIFT_L;
    else if (h == CH_LESS && c == CH_HASH) k = KIND_MACRO_O;
    else if (h == CH_LESS && c == CH_EQUAL) k = KIND_EQ_SMALLER;
    else if (h == CH_GREATER && c == CH_GREATER) k = KIND_BITSHIFT_R;
    else if (h == CH_GREATER && c == CH_EQUAL) k = KIND_EQ_GREATER;
    else if (h == CH_HASH && c == CH_GREATER) k = KIND_MACRO_C;
    else if (h == CH_COLON && c == CH_COLON) k = KIND_RANGE;
    return k;
  endfunction

  function automatic offset_t inc_offset(input offset_t v);
    return (v == '1) ? v : v + OFFSET_BITS'(1);
  endfunction

  function automatic line_t inc_line(input line_t v);
    return (v == '1) ? v : v + LINE_BITS'(1);
  endfunction

  function automatic col_t inc_col(input col_t v);
    return (v == '1) ? v : v + COL_BITS'(1);
  endfunction

  function automatic len_t inc_len(input len_t v);
    return (v == '1) ? v : v + LEN_BITS'(1);
  endfunction

endpackage

`default_nettype wire

/* hdl/asl_core.sv */
// ----------------------------------------------------------------------------
// asl_core: lexer state and per-byte decode
// Holds the scan mode, the pending token and the source position, and turns
// one registered request into at most two result records per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asl_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire logic [7:0]    byte_in,
  input  wire logic          at_end,
  output asl_pkg::push_t     push
);
  import asl_pkg::*;

  mode_t   mode, mode_next;
  logic [7:0] held_char, held_char_next;
  line_t   cur_line, cur_line_next;
  col_t    cur_column, cur_column_next;
  offset_t cur_offset, cur_offset_next;
  offset_t tok_offset, tok_offset_next;
  line_t   tok_line, tok_line_next;
  col_t    tok_column, tok_column_next;
  len_t    tok_length, tok_length_next;
  logic    last_was_newline, last_was_newline_next;
  logic    prev_backslash, prev_backslash_next;
  logic    halted, halted_next;

  logic    act;
  mode_t   fresh_mode;
  kind_t   fresh_kind;
  kind_t   str_kind;
  kind_t   hold_pair;
  logic    a_valid, a_err;
  kind_t   a_kind;
  len_t    a_len;
  logic    do_fresh, len_step, go_idle, go_comment, go_halt;
  logic    eot, fresh_emit;

  assign act      = fire && !halted;
  assign str_kind = (held_char == CH_DQUOTE) ? KIND_STRING_DB : KIND_STRING_SG;
  assign hold_pair = pair_kind(held_char, byte_in);

  // classify a byte that starts a new token
  always_comb begin
    fresh_mode = MODE_IDLE;
    fresh_kind = KIND_NONE;
    if (is_hold_lead(byte_in)) begin
      fresh_mode = MODE_HOLD;
    end else if (byte_in == CH_LF || byte_in == CH_SEMI) begin
      fresh_kind = KIND_NEWLINE;
    end else if (is_digit(byte_in)) begin
      fresh_mode = MODE_NUMBER;
    end else if (byte_in == CH_DQUOTE || byte_in == CH_SQUOTE) begin
      fresh_mode = MODE_STRING;
    end else if (is_letter(byte_in) || byte_in == CH_UNDER) begin
      fresh_mode = MODE_WORD;
    end else begin
      fresh_kind = single_kind(byte_in);
    end
  end

  // decide what the current mode does with this request
  always_comb begin
    a_valid    = 1'b0;
    a_err      = 1'b0;
    a_kind     = KIND_NONE;
    a_len      = tok_length;
    do_fresh   = 1'b0;
    len_step   = 1'b0;
    go_idle    = 1'b0;
    go_comment = 1'b0;
    go_halt    = 1'b0;
    if (act && at_end) begin
      case (mode)
        MODE_WORD: begin
          a_valid = 1'b1;
          a_kind  = KIND_WORD;
        end
        MODE_NUMBER: begin
          a_valid = 1'b1;
          a_kind  = KIND_NUMBER;
        end
        MODE_HOLD: begin
          a_valid = 1'b1;
          a_kind  = single_kind(held_char);
          a_len   = LEN_BITS'(1);
        end
        MODE_STRING: begin
          a_valid = 1'b1;
          a_kind  = str_kind;
          a_err   = 1'b1;
          go_halt = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (act) begin
      case (mode)
        MODE_COMMENT: begin
          do_fresh = (byte_in == CH_LF);
        end
        MODE_WORD: begin
          if (is_letter(byte_in) || is_digit(byte_in) || byte_in == CH_UNDER) begin
            len_step = 1'b1;
          end else begin
            a_valid  = 1'b1;
            a_kind   = KIND_WORD;
            do_fresh = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_num_tail(byte_in)) begin
            len_step = 1'b1;
          end else begin
            a_valid  = 1'b1;
            a_kind   = KIND_NUMBER;
            do_fresh = 1'b1;
          end
        end
        MODE_STRING: begin
          if (byte_in == held_char && !prev_backslash) begin
            a_valid = 1'b1;
            a_kind  = str_kind;
            go_idle = 1'b1;
          end else if (byte_in == CH_LF) begin
            a_valid = 1'b1;
            a_kind  = str_kind;
            a_err   = 1'b1;
            go_halt = 1'b1;
          end else begin
            len_step = 1'b1;
          end
        end
        MODE_HOLD: begin
          if (held_char == CH_SLASH && byte_in == CH_SLASH) begin
            go_comment = 1'b1;
          end else if (hold_pair != KIND_NONE) begin
            a_valid = 1'b1;
            a_kind  = hold_pair;
            a_len   = LEN_BITS'(2);
            go_idle = 1'b1;
          end else begin
            a_valid  = 1'b1;
            a_kind   = single_kind(held_char);
            a_len    = LEN_BITS'(1);
            do_fresh = 1'b1;
          end
        end
        default: begin
          do_fresh = 1'b1;
        end
      endcase
    end
  end

  assign eot = act && at_end && !go_halt;
  assign fresh_emit = do_fresh && (fresh_kind != KIND_NONE) &&
                      !(fresh_kind == KIND_NEWLINE && last_was_newline && !a_valid);

  // next state
  always_comb begin
    mode_next             = mode;
    held_char_next        = held_char;
    cur_line_next         = cur_line;
    cur_column_next       = cur_column;
    cur_offset_next       = cur_offset;
    tok_offset_next       = tok_offset;
    tok_line_next         = tok_line;
    tok_column_next       = tok_column;
    tok_length_next       = tok_length;
    last_was_newline_next = last_was_newline;
    prev_backslash_next   = prev_backslash;
    halted_next           = halted;
    if (go_halt) begin
      halted_next = 1'b1;
      mode_next   = MODE_IDLE;
    end else if (eot) begin
      mode_next             = MODE_IDLE;
      held_char_next        = 8'd0;
      cur_line_next         = LINE_BITS'(1);
      cur_column_next       = '0;
      cur_offset_next       = '0;
      tok_offset_next       = '0;
      tok_line_next         = LINE_BITS'(1);
      tok_column_next       = '0;
      tok_length_next       = '0;
      last_was_newline_next = 1'b0;
      prev_backslash_next   = 1'b0;
    end else if (act) begin
      if (len_step) begin
        tok_length_next = inc_len(tok_length);
        if (mode == MODE_STRING) begin
          prev_backslash_next = (byte_in == CH_BSLASH);
        end
      end
      if (go_idle) begin
        mode_next = MODE_IDLE;
      end
      if (go_comment) begin
        mode_next = MODE_COMMENT;
      end
      if (do_fresh) begin
        mode_next       = fresh_mode;
        tok_offset_next = cur_offset;
        tok_line_next   = cur_line;
        tok_column_next = cur_column;
        tok_length_next = LEN_BITS'(1);
        if (fresh_mode == MODE_HOLD) begin
          held_char_next = byte_in;
        end
        if (fresh_mode == MODE_STRING) begin
          held_char_next      = byte_in;
          tok_offset_next     = inc_offset(cur_offset);
          tok_length_next     = '0;
          prev_backslash_next = 1'b0;
        end
      end
      if (fresh_emit) begin
        last_was_newline_next = (fresh_kind == KIND_NEWLINE);
      end else if (a_valid) begin
        last_was_newline_next = 1'b0;
      end
      cur_offset_next = inc_offset(cur_offset);
      if (byte_in == CH_LF) begin
        cur_line_next   = inc_line(cur_line);
        cur_column_next = '0;
      end else begin
        cur_column_next = inc_col(cur_column);
      end
    end
  end

  // result records
  always_comb begin
    push.a_valid        = a_valid;
    push.a.kind         = a_kind;
    push.a.start_offset = tok_offset;
    push.a.line_no      = tok_line;
    push.a.column       = tok_column;
    push.a.length       = a_len;
    push.a.error        = a_err;
    push.a.last         = 1'b0;
    push.b_valid        = eot || fresh_emit;
    push.b.kind         = eot ? KIND_EOT : fresh_kind;
    push.b.start_offset = cur_offset;
    push.b.line_no      = cur_line;
    push.b.column       = cur_column;
    push.b.length       = eot ? '0 : LEN_BITS'(1);
    push.b.error        = 1'b0;
    push.b.last         = eot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_IDLE;
      held_char        <= 8'd0;
      cur_line         <= LINE_BITS'(1);
      cur_column       <= '0;
      cur_offset       <= '0;
      tok_offset       <= '0;
      tok_line         <= LINE_BITS'(1);
      tok_column       <= '0;
      tok_length       <= '0;
      last_was_newline <= 1'b0;
      prev_backslash   <= 1'b0;
      halted           <= 1'b0;
    end else begin
      mode             <= mode_next;
      held_char        <= held_char_next;
      cur_line         <= cur_line_next;
      cur_column       <= cur_column_next;
      cur_offset       <= cur_offset_next;
      tok_offset       <= tok_offset_next;
      tok_line         <= tok_line_next;
      tok_column       <= tok_column_next;
      tok_length       <= tok_length_next;
      last_was_newline <= last_was_newline_next;
      prev_backslash   <= prev_backslash_next;
      halted           <= halted_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/asl_queue.sv */
// ----------------------------------------------------------------------------
// asl_queue: result queue
// Small circular buffer that takes up to two result records per cycle and
// presents one at a time on the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asl_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire asl_pkg::push_t push,
  input  wire logic          pop,
  output logic               room2,
  output logic               not_empty,
  output asl_pkg::result_t   head_data
);
  import asl_pkg::*;

  result_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]    head, head_next;
  logic [PTR_BITS-1:0]    tail, tail_next;
  logic [PTR_BITS:0]      count, count_next;
  logic [PTR_BITS-1:0]    tail_plus1;
  logic [PTR_BITS:0]      n_push;

  assign tail_plus1 = tail + PTR_BITS'(1);
  assign n_push     = (PTR_BITS+1)'(push.a_valid) + (PTR_BITS+1)'(push.b_valid);
  assign room2      = count <= (PTR_BITS+1)'(QUEUE_DEPTH - 2);
  assign not_empty  = count != '0;
  assign head_data  = entries[head];

  always_comb begin
    head_next  = pop ? head + PTR_BITS'(1) : head;
    tail_next  = tail + n_push[PTR_BITS-1:0];
    count_next = count + n_push - (PTR_BITS+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      entries[tail] <= push.a;
      if (push.b_valid) begin
        entries[tail_plus1] <= push.b;
      end
    end else if (push.b_valid) begin
      entries[tail] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/assembler_source_lexer.sv */
// A taken byte is held in a request register; its tokens then enter the queue.
// Throughput: one source byte per cycle while the output channel keeps up;
// a byte yields zero, one or two tokens, buffered in a four-entry queue.
// Input stalls only when the queue cannot take two more tokens.
// Reset (rst, synchronous): position line 1 column 0, queue empty, halt cleared.
// ----------------------------------------------------------------------------
// assembler_source_lexer: assembler source tokenizer
// Scans a byte stream and emits word, number, string, punctuation, newline
// and end-of-text tokens with offset, line, column and length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module assembler_source_lexer (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       byte_in,
  input  wire logic                             at_end,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [asl_pkg::KIND_BITS-1:0]         kind,
  output logic [asl_pkg::OFFSET_BITS-1:0]       start_offset,
  output logic [asl_pkg::LINE_BITS-1:0]         line_no,
  output logic [asl_pkg::COL_BITS-1:0]          column,
  output logic [asl_pkg::LEN_BITS-1:0]          length,
  output logic                                  error,
  output logic                                  last
);
  import asl_pkg::*;

  logic       req_valid;
  logic [7:0] req_byte;
  logic       req_end;
  logic       accept;
  logic       fire;
  logic       room2;
  logic       pop;
  push_t      push;
  result_t    head_data;

  assign fire     = req_valid && room2;
  assign in_stall = req_valid && !room2;
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (accept) begin
      req_valid <= 1'b1;
    end else if (fire) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_byte <= byte_in;
      req_end  <= at_end;
    end
  end

  asl_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .byte_in (req_byte),
    .at_end  (req_end),
    .push    (push)
  );

  asl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .room2     (room2),
    .not_empty (out_valid),
    .head_data (head_data)
  );

  assign kind         = head_data.kind;
  assign start_offset = head_data.start_offset;
  assign line_no      = head_data.line_no;
  assign column       = head_data.column;
  assign length       = head_data.length;
  assign error        = head_data.error;
  assign last         = head_data.last;

`ifndef NO_ASSERTIONS
  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty result queue");

  a_error_is_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && error) |=> !out_valid)
    else $error("result delivered after an unterminated string");

  a_last_is_eot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (kind == KIND_EOT && !error))
    else $error("end-of-tokens flag on a wrong result");
`endif

endmodule

`default_nettype wire
